[hw/rtl/calendar_clock_with_set_buttons_defines.svh]
// Assertion macros for the calendar clock block.
`ifndef CALENDAR_CLOCK_WITH_SET_BUTTONS_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_SET_BUTTONS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// ante |-> cons, checked on clk outside reset
`define CCSB_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// ante |=> cons, checked on clk outside reset
`define CCSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCSB_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CCSB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/rtcc_pkg.sv]
// Types, constants and calendar helpers for the calendar clock block.
package rtcc_pkg;

	localparam int TICKS_PER_SECOND = 1000;
	localparam int MS_W = $clog2(TICKS_PER_SECOND);
	localparam logic [MS_W:0] TICKS_LIM = (MS_W + 1)'(TICKS_PER_SECOND);
	localparam logic [15:0] BLINK_MS = 16'd550;
	localparam int REFRESH_MS = 50;
	localparam int PH_W = $clog2(REFRESH_MS);
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(REFRESH_MS - 1);

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam int BTN_TSEL = 0;
	localparam int BTN_TUP = 1;
	localparam int BTN_TDN = 2;
	localparam int BTN_DSEL = 3;
	localparam int BTN_DUP = 4;
	localparam int BTN_DDN = 5;

	localparam logic [1:0] TSEL_HOUR = 2'd1;
	localparam logic [1:0] TSEL_MIN = 2'd2;
	localparam logic [1:0] TSEL_SEC = 2'd3;
	localparam logic [1:0] DSEL_DAY = 2'd1;
	localparam logic [1:0] DSEL_MONTH = 2'd2;
	localparam logic [1:0] DSEL_YEAR = 2'd3;

	typedef struct packed {
		logic       func;
		logic [5:0] buttons;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic        leap_flag;
		logic [1:0]  time_select;
		logic [1:0]  date_select;
		logic        blink_phase;
		logic        refresh;
	} out_word_t;

	typedef struct packed {
		logic [MS_W-1:0] millis;
		logic [PH_W-1:0] phase;
		logic [5:0]      sec;
		logic [5:0]      min;
		logic [4:0]      hour;
		logic [4:0]      day;
		logic [3:0]      month;
		logic [15:0]     year;
		logic            leap;
		logic [1:0]      tsel;
		logic [1:0]      dsel;
		logic [5:0]      last_btn;
	} clk_state_t;

	localparam clk_state_t STATE_RESET = '{
		millis: '0, phase: '0, sec: 6'd57, min: 6'd59, hour: 5'd23,
		day: 5'd28, month: 4'd2, year: 16'd2001, leap: 1'b0,
		tsel: 2'd0, dsel: 2'd0, last_btn: 6'd0
	};

	function automatic logic is_leap(logic [15:0] y);
		return (y >= 16'd1904) && (y < 16'd2100) && (y[1:0] == 2'd0);
	endfunction

	function automatic logic [4:0] days_in_month(logic [3:0] m, logic leap);
		logic [4:0] d;
		case (m) inside
			4'd2:                    d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[hw/rtl/rtcc_if.sv]
// Valid/ready channel interfaces for input and result words.
interface rtcc_in_if import rtcc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rtcc_out_if import rtcc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/rtcc_step.sv]
// Next-state logic: millisecond tick cascade and button set handling.
module rtcc_step import rtcc_pkg::*; (
	input  clk_state_t cur,
	input  logic       func,
	input  logic [5:0] buttons,
	output clk_state_t nxt
);

	always_comb begin
		logic [MS_W:0] ms_inc;
		logic [4:0]    dim;
		logic [5:0]    fall;
		logic [1:0]    tsel;
		logic [1:0]    dsel;
		logic [15:0]   yr;
		logic          up_t, dn_t, up_d, dn_d;

		nxt = cur;
		dim = days_in_month(cur.month, cur.leap);
		ms_inc = {1'b0, cur.millis} + {{MS_W{1'b0}}, 1'b1};
		fall = cur.last_btn & ~buttons;
		up_t = fall[BTN_TUP];
		dn_t = fall[BTN_TDN];
		up_d = fall[BTN_DUP];
		dn_d = fall[BTN_DDN];
		tsel = cur.tsel + {1'b0, fall[BTN_TSEL]};
		dsel = cur.dsel + {1'b0, fall[BTN_DSEL]};
		yr = cur.year;

		if (func == FUNC_TICK) begin
			if (ms_inc < TICKS_LIM) begin
				nxt.millis = ms_inc[MS_W-1:0];
				nxt.phase = (cur.phase == PH_LAST) ? '0 : cur.phase + PH_W'(1);
			end else begin
				nxt.millis = '0;
				nxt.phase = '0;
				if (cur.sec < 6'd59) begin
					nxt.sec = cur.sec + 6'd1;
				end else begin
					nxt.sec = '0;
					if (cur.min < 6'd59) begin
						nxt.min = cur.min + 6'd1;
					end else begin
						nxt.min = '0;
						if (cur.hour < 5'd23) begin
							nxt.hour = cur.hour + 5'd1;
						end else begin
							nxt.hour = '0;
							if (cur.day >= dim) begin
								nxt.day = 5'd1;
								if (cur.month >= 4'd12) begin
									nxt.month = 4'd1;
									yr = cur.year + 16'd1;
									nxt.year = yr;
									nxt.leap = is_leap(yr);
								end else begin
									nxt.month = cur.month + 4'd1;
								end
							end else begin
								nxt.day = cur.day + 5'd1;
							end
						end
					end
				end
			end
		end else begin
			nxt.tsel = tsel;
			nxt.dsel = dsel;
			case (tsel)
				TSEL_HOUR: begin
					if (up_t) nxt.hour = (nxt.hour >= 5'd23) ? 5'd0 : nxt.hour + 5'd1;
					if (dn_t) nxt.hour = (nxt.hour == 5'd0) ? 5'd23 : nxt.hour - 5'd1;
				end
				TSEL_MIN: begin
					if (up_t) nxt.min = (nxt.min >= 6'd59) ? 6'd0 : nxt.min + 6'd1;
					if (dn_t) nxt.min = (nxt.min == 6'd0) ? 6'd59 : nxt.min - 6'd1;
				end
				TSEL_SEC: begin
					if (up_t) nxt.sec = (nxt.sec >= 6'd59) ? 6'd0 : nxt.sec + 6'd1;
					if (dn_t) nxt.sec = (nxt.sec == 6'd0) ? 6'd59 : nxt.sec - 6'd1;
				end
				default: ;
			endcase
			case (dsel)
				DSEL_DAY: begin
					if (up_d) nxt.day = (nxt.day >= dim) ? 5'd1 : nxt.day + 5'd1;
					if (dn_d) nxt.day = (nxt.day <= 5'd1) ? dim : nxt.day - 5'd1;
				end
				DSEL_MONTH: begin
					if (up_d) nxt.month = (nxt.month >= 4'd12) ? 4'd1 : nxt.month + 4'd1;
					if (dn_d) nxt.month = (nxt.month <= 4'd1) ? 4'd12 : nxt.month - 4'd1;
				end
				DSEL_YEAR: begin
					if (up_d) yr = yr + 16'd1;
					if (dn_d) yr = yr - 16'd1;
					if (up_d || dn_d) begin
						nxt.year = yr;
						nxt.leap = is_leap(yr);
					end
				end
				default: ;
			endcase
			nxt.last_btn = buttons;
		end
	end

endmodule

[hw/rtl/calendar_clock_with_set_buttons.sv]
// Real-time clock and calendar with six active-low set buttons.
// Each input word is a millisecond tick or a button sample; every accepted word yields one
// result word with the updated clock, selectors and blink/refresh flags. A new word is taken
// every cycle while ready is high; a word passes through the input register, then the
// state update into the result register, and the result is held there until the sink takes it.
// Ready drops only while both registers hold words and the sink stalls.
// Reset time is 23:59:57 on 28 Feb 2001.
`include "calendar_clock_with_set_buttons_defines.svh"

module calendar_clock_with_set_buttons import rtcc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rtcc_in_if.sink     tick_in,
	rtcc_out_if.source  clock_out
);

	logic       valid_s1;
	in_word_t   word_s1;
	logic       valid_s2;
	out_word_t  word_s2;
	clk_state_t state_q;
	clk_state_t state_nxt;
	out_word_t  result;
	logic       adv;

	assign adv = valid_s1 && (!valid_s2 || clock_out.ready);
	assign tick_in.ready = !valid_s1 || adv;
	assign clock_out.valid = valid_s2;
	assign clock_out.data = word_s2;

	rtcc_step u_step (
		.cur     (state_q),
		.func    (word_s1.func),
		.buttons (word_s1.buttons),
		.nxt     (state_nxt)
	);

	always_comb begin
		result.hours = state_nxt.hour;
		result.minutes = state_nxt.min;
		result.seconds = state_nxt.sec;
		result.day = state_nxt.day;
		result.month = state_nxt.month;
		result.year = state_nxt.year;
		result.leap_flag = state_nxt.leap;
		result.time_select = state_nxt.tsel;
		result.date_select = state_nxt.dsel;
		result.blink_phase = 16'(state_nxt.millis) > BLINK_MS;
		result.refresh = (state_nxt.phase == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= STATE_RESET;
		end else begin
			if (tick_in.ready) valid_s1 <= tick_in.valid;
			if (adv) begin
				valid_s2 <= 1'b1;
				state_q <= state_nxt;
			end else if (clock_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in.valid && tick_in.ready) word_s1 <= tick_in.data;
		if (adv) word_s2 <= result;
	end

	`CCSB_ASSERT_IMPLY(a_no_adv_on_stall, valid_s2 && !clock_out.ready, !adv,
		"word advanced into a held result register")
	`CCSB_ASSERT_IMPLY(a_sec_range, 1'b1, state_q.sec < 6'd60, "seconds out of range")
	`CCSB_ASSERT_IMPLY(a_phase_range, 1'b1, state_q.phase <= PH_LAST, "refresh phase out of range")
	`CCSB_ASSERT_IMPLY(a_month_moves_on_adv, state_q.month != $past(state_q.month),
		$past(adv), "month changed without a word")
	`CCSB_ASSERT_NEXT(a_result_follows, adv, valid_s2, "processed word produced no result")

endmodule
